/* hdl/base32_stream_codec_defines.svh */
// ---------------------------------------------------------------------------
// base32_stream_codec_defines.svh
// Assertion macros shared by the codec's checker.
// ---------------------------------------------------------------------------
`ifndef BASE32_STREAM_CODEC_DEFINES_SVH
`define BASE32_STREAM_CODEC_DEFINES_SVH

// same-cycle implication, quiet during reset
`define B32_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("b32 assertion failed");

// next-cycle implication, quiet during reset
`define B32_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("b32 assertion failed");

// implication that also holds across reset
`define B32_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("b32 assertion failed");

`endif

/* hdl/b32_pkg.sv */
// ---------------------------------------------------------------------------
// b32_pkg
// Widths, register indexes, result group type and alphabet helpers.
// ---------------------------------------------------------------------------
package b32_pkg;

  localparam int unsigned ValW     = 8;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned MaxRes   = 3;
  localparam int unsigned ResCntW  = 2;

  localparam logic [CfgIdxW-1:0] CfgModeIdx  = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgLimitIdx = 4'd1;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  localparam logic [LimitW-1:0] LimitReset = 16'd24;

  // results produced by one input item
  typedef struct packed {
    logic [ResCntW-1:0]             count;
    logic [MaxRes-1:0][ValW-1:0]    value;
    logic                           msg_last;
  } b32_group_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] sym;
  } b32_sym_t;

  // 5-bit symbol to alphabet character (A-Z, 2-7)
  function automatic logic [ValW-1:0] sym_char(input logic [4:0] s);
    logic [ValW-1:0] w;
    w = {3'b000, s};
    if (s < 5'd26) begin
      return 8'h41 + w;
    end
    return 8'h18 + w;
  endfunction

  // character to 5-bit symbol; A-Z and a-z share 0-25, 2-7 give 26-31
  function automatic b32_sym_t char_sym(input logic [ValW-1:0] c);
    b32_sym_t r;
    logic [ValW-1:0] d;
    r = '0;
    d = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      r.ok = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61;
      r.ok = 1'b1;
    end else if (c >= 8'h32 && c <= 8'h37) begin
      d = c - 8'h18;
      r.ok = 1'b1;
    end
    r.sym = d[4:0];
    return r;
  endfunction

endpackage

/* hdl/b32_if.sv */
// ---------------------------------------------------------------------------
// b32 stream interfaces
// Input item, result item and configuration write channels.
// ---------------------------------------------------------------------------
interface b32_in_if;
  import b32_pkg::*;
  logic            valid;
  logic            ready;
  logic [ValW-1:0] in_value;
  logic            in_last;
  modport source (output valid, in_value, in_last, input ready);
  modport sink   (input valid, in_value, in_last, output ready);
endinterface

interface b32_out_if;
  import b32_pkg::*;
  logic            valid;
  logic            ready;
  logic [ValW-1:0] out_value;
  logic            out_run_end;
  logic            out_msg_end;
  modport source (output valid, out_value, out_run_end, out_msg_end, input ready);
  modport sink   (input valid, out_value, out_run_end, out_msg_end, output ready);
endinterface

interface b32_cfg_if;
  import b32_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/b32_core.sv */
// ---------------------------------------------------------------------------
// b32_core
// Message state and the per-item encode/decode step.
// ---------------------------------------------------------------------------
module b32_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        step_i,
  input  logic                        mode_i,
  input  logic [b32_pkg::LimitW-1:0]  out_limit_i,
  input  logic [b32_pkg::ValW-1:0]    value_i,
  input  logic                        last_i,
  output b32_pkg::b32_group_t         group_o
);
  import b32_pkg::*;

  logic [7:0]        store_q, store_d;
  logic [2:0]        count_q, count_d;
  logic [LimitW-1:0] bytes_q, bytes_d;
  logic              hit_q, hit_d;

  // encode path
  logic [2:0]  e_cnt;
  logic [7:0]  e_keep;
  logic [11:0] e_acc;
  logic [3:0]  e_tot;
  logic        e_two;
  logic [11:0] e_sh0, e_sh1;
  logic [2:0]  e_rem;
  logic [11:0] e_mask;
  logic [7:0]  e_store;
  logic [7:0]  e_fsh;
  logic        e_flush;

  // decode path
  b32_sym_t          d_sym;
  logic              d_blk0, d_take, d_emit;
  logic [3:0]        d_cnt, d_cnt2;
  logic [11:0]       d_acc, d_sh, d_mask;
  logic [7:0]        d_byte1, d_byte2, d_store;
  logic [2:0]        d_count;
  logic [LimitW-1:0] d_bytes;
  logic              d_hit, d_blk1, d_flush;

  b32_group_t grp;

  always_comb begin
    e_cnt   = (count_q > 3'd4) ? 3'd0 : count_q;
    e_keep  = store_q & ((8'd1 << e_cnt) - 8'd1);
    e_acc   = {e_keep[3:0], value_i};
    e_tot   = {1'b0, e_cnt} + 4'd8;
    e_two   = (e_tot >= 4'd10);
    e_sh0   = e_acc >> (e_tot - 4'd5);
    e_sh1   = e_acc >> (e_tot - 4'd10);
    e_rem   = e_two ? 3'(e_tot - 4'd10) : 3'(e_tot - 4'd5);
    e_mask  = (12'd1 << e_rem) - 12'd1;
    e_store = 8'(e_acc & e_mask);
    e_fsh   = e_store << (3'd5 - e_rem);
    e_flush = last_i && (e_rem != 3'd0);
  end

  always_comb begin
    d_sym   = char_sym(value_i);
    d_blk0  = hit_q || (bytes_q >= out_limit_i);
    d_take  = d_sym.ok && !d_blk0;
    d_cnt   = {1'b0, count_q} + 4'd5;
    d_acc   = {store_q[6:0], d_sym.sym};
    d_emit  = d_take && (d_cnt >= 4'd8);
    d_sh    = d_acc >> (d_cnt - 4'd8);
    d_byte1 = d_sh[7:0];
    d_cnt2  = (d_cnt >= 4'd8) ? (d_cnt - 4'd8) : d_cnt;
    d_mask  = (12'd1 << d_cnt2) - 12'd1;
    d_store = d_take ? 8'(d_acc & d_mask) : store_q;
    d_count = d_take ? d_cnt2[2:0] : count_q;
    d_bytes = bytes_q + {{(LimitW-1){1'b0}}, d_emit};
    d_hit   = hit_q || (d_emit && (d_bytes >= out_limit_i));
    d_blk1  = d_hit || (d_bytes >= out_limit_i);
    d_flush = last_i && (d_count != 3'd0) && !d_blk1;
    d_byte2 = d_store << (3'd0 - d_count);  // shift by 8 - count, mod 8
  end

  always_comb begin
    grp = '0;
    grp.msg_last = last_i;
    if (mode_i == ModeEncode) begin
      grp.value[0] = sym_char(e_sh0[4:0]);
      grp.value[1] = e_two ? sym_char(e_sh1[4:0]) : sym_char(e_fsh[4:0]);
      grp.value[2] = sym_char(e_fsh[4:0]);
      grp.count    = 2'd1 + {1'b0, e_two} + {1'b0, e_flush};
    end else begin
      grp.value[0] = d_emit ? d_byte1 : d_byte2;
      grp.value[1] = d_byte2;
      grp.count    = {1'b0, d_emit} + {1'b0, d_flush};
    end
  end

  assign group_o = grp;

  always_comb begin
    store_d = store_q;
    count_d = count_q;
    bytes_d = bytes_q;
    hit_d   = hit_q;
    if (clear_i || (step_i && last_i)) begin
      store_d = '0;
      count_d = '0;
      bytes_d = '0;
      hit_d   = 1'b0;
    end else if (step_i) begin
      if (mode_i == ModeEncode) begin
        store_d = e_store;
        count_d = e_rem;
      end else begin
        store_d = d_store;
        count_d = d_count;
        bytes_d = d_bytes;
        hit_d   = d_hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      count_q <= '0;
      bytes_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      store_q <= store_d;
      count_q <= count_d;
      bytes_q <= bytes_d;
      hit_q   <= hit_d;
    end
  end

endmodule

/* hdl/b32_emit.sv */
// ---------------------------------------------------------------------------
// b32_emit
// Result register: holds one result group and sends it one item a cycle while the output is ready.
// ---------------------------------------------------------------------------
module b32_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  b32_pkg::b32_group_t group_i,
  output logic                ready_o,
  b32_out_if.source           out_o
);
  import b32_pkg::*;

  logic [MaxRes-1:0][ValW-1:0] vals_q;
  logic [ResCntW-1:0]          rem_q, rem_d;
  logic [ResCntW-1:0]          idx_q, idx_d;
  logic                        msg_q;
  logic                        xfer, load;

  assign xfer    = out_o.valid && out_o.ready;
  assign ready_o = (rem_q == '0) || (xfer && (rem_q == 2'd1));
  assign load    = load_i && ready_o;

  assign out_o.valid       = (rem_q != '0);
  assign out_o.out_value   = vals_q[idx_q];
  assign out_o.out_run_end = (rem_q == 2'd1);
  assign out_o.out_msg_end = (rem_q == 2'd1) && msg_q;

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (load) begin
      rem_d = group_i.count;
      idx_d = '0;
    end else if (xfer) begin
      rem_d = rem_q - 2'd1;
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      vals_q <= group_i.value;
      msg_q  <= group_i.msg_last;
    end
  end

endmodule

/* hdl/base32_stream_codec.sv */
// ---------------------------------------------------------------------------
// base32_stream_codec
// Unpadded base32 encoder/decoder (alphabet A-Z, 2-7) on item streams.
// ---------------------------------------------------------------------------
//  channel | dir | payload                              | transfer when
//  --------+-----+--------------------------------------+-------------------
//  in_i    | in  | in_value[7:0], in_last               | valid && ready
//  out_o   | out | out_value[7:0], out_run_end, msg_end | valid && ready
//  cfg_i   | in  | index[3:0], data[15:0]               | valid && ready
//
//  An item waits in the input register, then its whole step is resolved
//  into a result group in one pass; the group drains through the single
//  output port at one result per cycle while out_o is ready. An item gives
//  1 to 3 results in encode and 0 to 2 in decode. Input is taken while the
//  last result of the previous group leaves. Reset clears all message state
//  and the registers (mode=encode, out_limit=24). Output stalls back up into
//  in_i.ready.
// ---------------------------------------------------------------------------
module base32_stream_codec (
  input  logic      clk_i,
  input  logic      rst_ni,
  b32_in_if.sink    in_i,
  b32_out_if.source out_o,
  b32_cfg_if.sink   cfg_i
);
  import b32_pkg::*;

  // configuration registers
  logic              mode_q;
  logic [LimitW-1:0] limit_q;
  logic              cfg_xfer;
  logic              mode_wr;

  // input register
  logic            s1_valid_q;
  logic [ValW-1:0] s1_value_q;
  logic            s1_last_q;

  logic       emit_ready;
  logic       s1_move;
  logic       in_xfer;
  b32_group_t group;

  // config is always taken; writes must only arrive while the codec is idle (the block does not enforce it)
  assign cfg_i.ready = 1'b1;
  assign cfg_xfer    = cfg_i.valid && cfg_i.ready;
  assign mode_wr     = cfg_xfer && (cfg_i.index == CfgModeIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeEncode;
      limit_q <= LimitReset;
    end else if (cfg_xfer) begin
      unique case (cfg_i.index)
        CfgModeIdx:  mode_q  <= cfg_i.data[0];
        CfgLimitIdx: limit_q <= cfg_i.data[LimitW-1:0];
        default: ;  // unknown register: dropped
      endcase
    end
  end

  // item moves on when the result register can take its group
  assign s1_move    = s1_valid_q && emit_ready;
  assign in_i.ready = !s1_valid_q || emit_ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_value_q <= in_i.in_value;
      s1_last_q  <= in_i.in_last;
    end
  end

  // step logic and message state; a mode write starts a fresh message
  b32_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (mode_wr),
    .step_i      (s1_move),
    .mode_i      (mode_q),
    .out_limit_i (limit_q),
    .value_i     (s1_value_q),
    .last_i      (s1_last_q),
    .group_o     (group)
  );

  // result register and serializer
  b32_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s1_valid_q),
    .group_i (group),
    .ready_o (emit_ready),
    .out_o   (out_o)
  );

endmodule

/* hdl/b32_checker.sv */
// ---------------------------------------------------------------------------
// b32_checker
// Port-level checks of the codec, bound to the top level.
// ---------------------------------------------------------------------------
`include "base32_stream_codec_defines.svh"

module b32_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_run_end_i,
  input logic out_msg_end_i
);

  // a stalled result stays offered
  `B32_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // the end of a message is always the end of its item's run
  `B32_ASSERT_IMP(a_msg_run, clk_i, rst_ni, out_valid_i && out_msg_end_i, out_run_end_i)

  // input only backs up while results are pending
  `B32_ASSERT_IMP(a_stall_src, clk_i, rst_ni, !in_ready_i, out_valid_i)

  // nothing is offered right out of reset
  `B32_ASSERT_ALWAYS(a_rst_quiet, clk_i, $rose(rst_ni), !out_valid_i)

endmodule

bind base32_stream_codec b32_checker u_b32_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_run_end_i (out_o.out_run_end),
  .out_msg_end_i (out_o.out_msg_end)
);
